FILE: rtl/core/gra_pkg.sv
// Shared types, constants and the arctangent table for the GPS reference averager.
// No dependencies; every other file of the block imports this package.
package gra_pkg;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_SAT_THRESHOLD   = 2'd0,
      CSR_SAMPLE_TARGET   = 2'd1,
      CSR_STABILITY_LIMIT = 2'd2,
      CSR_UNUSED          = 2'd3
   } csr_index_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_REJECTED = 2'd0,
      STATUS_ACCEPTED = 2'd1,
      STATUS_REF_SET  = 2'd2,
      STATUS_POSITION = 2'd3
   } status_type;

   localparam int COSINE_STEPS_DEFAULT = 18;

   localparam logic [7:0]  SAT_THRESHOLD_RESET   = 8'd10;
   localparam logic [15:0] SAMPLE_TARGET_RESET   = 16'd500;
   localparam logic [19:0] STABILITY_LIMIT_RESET = 20'd10;

   // Serial divider geometry: accumulated magnitude over the sample count.
   localparam int DIVIDEND_W = 48;
   localparam int DIVISOR_W  = 16;

   // 11.1195 mm per 1e-7 degree in Q5.24.
   localparam logic signed [28:0] MM_PER_UNIT_Q24 = 29'sd186554253;

   // CORDIC start value (gain-compensated) in Q4.30 and a quarter turn in 1e-7 degree.
   localparam logic signed [33:0] CORDIC_START_X = 34'sd652032874;
   localparam logic [32:0]        QUARTER_TURN   = 33'd900000000;

   // Arctangent of 2^-i in 1e-7 degree, rounded to nearest.
   function automatic logic [28:0] atan_lookup(input logic [4:0] idx);
      logic [28:0] val;
      case (idx)
         5'd0:  val = 29'd450000000;
         5'd1:  val = 29'd265650512;
         5'd2:  val = 29'd140362435;
         5'd3:  val = 29'd71250163;
         5'd4:  val = 29'd35763344;
         5'd5:  val = 29'd17899106;
         5'd6:  val = 29'd8951737;
         5'd7:  val = 29'd4476142;
         5'd8:  val = 29'd2238105;
         5'd9:  val = 29'd1119057;
         5'd10: val = 29'd559529;
         5'd11: val = 29'd279765;
         5'd12: val = 29'd139882;
         5'd13: val = 29'd69941;
         5'd14: val = 29'd34971;
         5'd15: val = 29'd17485;
         5'd16: val = 29'd8743;
         5'd17: val = 29'd4371;
         5'd18: val = 29'd2186;
         5'd19: val = 29'd1093;
         5'd20: val = 29'd546;
         5'd21: val = 29'd273;
         5'd22: val = 29'd137;
         5'd23: val = 29'd68;
         5'd24: val = 29'd34;
         5'd25: val = 29'd17;
         5'd26: val = 29'd9;
         5'd27: val = 29'd4;
         5'd28: val = 29'd2;
         5'd29: val = 29'd1;
         5'd30: val = 29'd1;
         default: val = 29'd0;
      endcase
      return val;
   endfunction

endpackage

FILE: rtl/core/gps_reference_averager_local_xy_unit.sv
// Top level of the GPS reference averager with local east/north projection.
// Depends on gra_pkg, gra_div (serial divider) and gra_cordic (cosine unit).
//
//   Channel  Direction  Signals                          Content
//   req      in         req_tvalid/tready/tdata[71:0]    one GPS fix per beat
//   rsp      out        rsp_tvalid/tready/tdata/tuser    one result per fix
//   csr      in         csr_we/csr_addr/csr_wdata        register writes
//
// A fix that is averaged or rejected goes through the check and finish states
// to the result register. The fix that completes the average runs the
// one-bit-per-cycle divider twice, for latitude and then longitude, and then
// the CORDIC loop. Once the reference is set, each fix is projected by the
// one shared multiplier, which is used four times in turn.
// The block takes one fix at a time: req_tready is high only when idle.
// A result waits in the output register until taken; while it waits the block
// may accept and work on the next fix, but holds its result until the slot is
// free. Reset is synchronous and clears all control and averaging state.
module gps_reference_averager_local_xy_unit import gra_pkg::*; #(
   parameter int COSINE_STEPS = COSINE_STEPS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   // req_tdata: latitude[30:0], longitude[62:31], satellites[70:63], zero pad [71]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [71:0]  req_tdata,
   // rsp_tdata: accepted_count[15:0], east_mm[52:16], north_mm[88:53],
   //            reference_latitude_out[119:89], reference_longitude_out[151:120]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [151:0] rsp_tdata,
   // rsp_tuser: status[1:0]
   output logic [1:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [19:0]  csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_LAT_GO,
      ST_DIV_LAT_WAIT,
      ST_DIV_LON_GO,
      ST_DIV_LON_WAIT,
      ST_COS_GO,
      ST_COS_WAIT,
      ST_MUL_NORTH,
      ST_MUL_EAST,
      ST_PART,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_EAST,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [7:0]  sat_thr_ff;
   logic [15:0] target_ff;
   logic [19:0] limit_ff;

   // Latched fix.
   logic signed [30:0] lat_ff, lat_in;
   logic signed [31:0] lon_ff, lon_in;
   logic [7:0]         sats_ff, sats_in;

   // Averaging and reference state.
   logic signed [30:0] prev_lat_ff, prev_lat_in;
   logic signed [31:0] prev_lon_ff, prev_lon_in;
   logic signed [46:0] lat_sum_ff, lat_sum_in;
   logic signed [47:0] lon_sum_ff, lon_sum_in;
   logic [15:0]        count_ff, count_in;
   logic signed [30:0] ref_lat_ff, ref_lat_in;
   logic signed [31:0] ref_lon_ff, ref_lon_in;
   logic [17:0]        cos_ff, cos_in;
   logic               ref_valid_ff, ref_valid_in;

   // Working registers of the shared multiplier path.
   logic signed [62:0] prod_ff, prod_in;
   logic signed [62:0] acc_ff, acc_in;
   logic signed [45:0] part_ff, part_in;
   logic signed [35:0] north_ff, north_in;
   logic signed [36:0] east_ff, east_in;
   status_type         status_ff, status_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [15:0]        rsp_count_ff, rsp_count_in;
   logic signed [36:0] rsp_east_ff, rsp_east_in;
   logic signed [35:0] rsp_north_ff, rsp_north_in;
   logic signed [30:0] rsp_ref_lat_ff, rsp_ref_lat_in;
   logic signed [31:0] rsp_ref_lon_ff, rsp_ref_lon_in;

   // Stability check.
   logic signed [32:0] dlat_chk, dlon_chk;
   logic [32:0]        abs_lat, abs_lon;
   logic               fix_ok;
   logic [16:0]        count_next;

   // Shared multiplier operands.
   logic signed [33:0] mul_a;
   logic signed [28:0] mul_b;
   logic signed [62:0] mul_p;
   logic signed [33:0] dlat, dlon;

   // Rounding and saturation.
   logic signed [62:0] north_full, part_full;
   logic signed [64:0] east_sum, east_full;

   // Divider and cosine unit.
   logic               div_start, div_done;
   logic [DIVIDEND_W-1:0] div_dividend, div_quotient;
   logic               cos_start, cos_done;
   logic [17:0]        cos_result;

   assign dlat_chk = {{2{lat_ff[30]}}, lat_ff} - {{2{prev_lat_ff[30]}}, prev_lat_ff};
   assign dlon_chk = {lon_ff[31], lon_ff} - {prev_lon_ff[31], prev_lon_ff};
   assign abs_lat  = dlat_chk[32] ? 33'(-dlat_chk) : dlat_chk;
   assign abs_lon  = dlon_chk[32] ? 33'(-dlon_chk) : dlon_chk;
   assign fix_ok   = (sats_ff >= sat_thr_ff) && (abs_lat < {13'b0, limit_ff})
                     && (abs_lon < {13'b0, limit_ff});
   assign count_next = {1'b0, count_ff} + 17'd1;

   assign dlat = {{3{lat_ff[30]}}, lat_ff} - {{3{ref_lat_ff[30]}}, ref_lat_ff};
   assign dlon = {{2{lon_ff[31]}}, lon_ff} - {{2{ref_lon_ff[31]}}, ref_lon_ff};

   // The multiplier operands follow the sequencer; east is formed from two
   // partial products, low 22 bits of the scaled longitude and the rest.
   always_comb begin
      case (state_ff)
         ST_MUL_NORTH: begin
            mul_a = dlat;
            mul_b = MM_PER_UNIT_Q24;
         end
         ST_MUL_EAST: begin
            mul_a = dlon;
            mul_b = MM_PER_UNIT_Q24;
         end
         ST_MUL_LO: begin
            mul_a = $signed({12'b0, part_ff[21:0]});
            mul_b = $signed({11'b0, cos_ff});
         end
         ST_MUL_HI: begin
            mul_a = {{10{part_ff[45]}}, part_ff[45:22]};
            mul_b = $signed({11'b0, cos_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign north_full = (prod_ff + 63'sd8388608) >>> 24;
   assign part_full  = (prod_ff + 63'sd65536) >>> 17;
   assign east_sum   = ({{2{prod_ff[62]}}, prod_ff} <<< 22) + {{2{acc_ff[62]}}, acc_ff};
   assign east_full  = (east_sum + 65'sd8388608) >>> 24;

   // Divider operand: magnitude of whichever sum is being averaged.
   always_comb begin
      if (state_ff == ST_DIV_LON_GO) begin
         div_dividend = lon_sum_ff[47] ? DIVIDEND_W'(-lon_sum_ff) : DIVIDEND_W'(lon_sum_ff);
      end else begin
         div_dividend = lat_sum_ff[46] ? DIVIDEND_W'(-{lat_sum_ff[46], lat_sum_ff})
                                       : DIVIDEND_W'({1'b0, lat_sum_ff});
      end
   end

   assign div_start = (state_ff == ST_DIV_LAT_GO) || (state_ff == ST_DIV_LON_GO);
   assign cos_start = (state_ff == ST_COS_GO);

   gra_div #(
      .DIVIDEND_BITS (DIVIDEND_W),
      .DIVISOR_BITS  (DIVISOR_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   gra_cordic #(
      .COSINE_STEPS (COSINE_STEPS)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cos_start),
      .angle  (ref_lat_ff),
      .done   (cos_done),
      .cosine (cos_result)
   );

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      lat_in         = lat_ff;
      lon_in         = lon_ff;
      sats_in        = sats_ff;
      prev_lat_in    = prev_lat_ff;
      prev_lon_in    = prev_lon_ff;
      lat_sum_in     = lat_sum_ff;
      lon_sum_in     = lon_sum_ff;
      count_in       = count_ff;
      ref_lat_in     = ref_lat_ff;
      ref_lon_in     = ref_lon_ff;
      cos_in         = cos_ff;
      ref_valid_in   = ref_valid_ff;
      prod_in        = prod_ff;
      acc_in         = acc_ff;
      part_in        = part_ff;
      north_in       = north_ff;
      east_in        = east_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_east_in    = rsp_east_ff;
      rsp_north_in   = rsp_north_ff;
      rsp_ref_lat_in = rsp_ref_lat_ff;
      rsp_ref_lon_in = rsp_ref_lon_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               lat_in   = $signed(req_tdata[30:0]);
               lon_in   = $signed(req_tdata[62:31]);
               sats_in  = req_tdata[70:63];
               north_in = '0;
               east_in  = '0;
               state_in = ref_valid_ff ? ST_MUL_NORTH : ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (fix_ok) begin
               lat_sum_in = lat_sum_ff + {{16{lat_ff[30]}}, lat_ff};
               lon_sum_in = lon_sum_ff + {{16{lon_ff[31]}}, lon_ff};
               count_in   = count_next[15:0];
               status_in  = STATUS_ACCEPTED;
               // A target of zero is met by the first accepted fix.
               state_in   = (count_next >= {1'b0, target_ff}) ? ST_DIV_LAT_GO : ST_FINISH;
            end else begin
               lat_sum_in = '0;
               lon_sum_in = '0;
               count_in   = '0;
               status_in  = STATUS_REJECTED;
               state_in   = ST_FINISH;
            end
            prev_lat_in = lat_ff;
            prev_lon_in = lon_ff;
         end
         ST_DIV_LAT_GO: begin
            state_in = ST_DIV_LAT_WAIT;
         end
         ST_DIV_LAT_WAIT: begin
            if (div_done) begin
               ref_lat_in = lat_sum_ff[46] ? 31'(-div_quotient[30:0]) : div_quotient[30:0];
               state_in   = ST_DIV_LON_GO;
            end
         end
         ST_DIV_LON_GO: begin
            state_in = ST_DIV_LON_WAIT;
         end
         ST_DIV_LON_WAIT: begin
            if (div_done) begin
               ref_lon_in = lon_sum_ff[47] ? 32'(-div_quotient[31:0]) : div_quotient[31:0];
               state_in   = ST_COS_GO;
            end
         end
         ST_COS_GO: begin
            state_in = ST_COS_WAIT;
         end
         ST_COS_WAIT: begin
            if (cos_done) begin
               cos_in       = cos_result;
               ref_valid_in = 1'b1;
               status_in    = STATUS_REF_SET;
               state_in     = ST_FINISH;
            end
         end
         ST_MUL_NORTH: begin
            prod_in  = mul_p;
            state_in = ST_MUL_EAST;
         end
         ST_MUL_EAST: begin
            if (north_full[62:35] == {28{north_full[62]}}) begin
               north_in = north_full[35:0];
            end else begin
               north_in = north_full[62] ? {1'b1, 35'b0} : {1'b0, {35{1'b1}}};
            end
            prod_in  = mul_p;
            state_in = ST_PART;
         end
         ST_PART: begin
            part_in  = part_full[45:0];
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            prod_in  = mul_p;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            acc_in   = prod_ff;
            prod_in  = mul_p;
            state_in = ST_EAST;
         end
         ST_EAST: begin
            if (east_full[64:36] == {29{east_full[64]}}) begin
               east_in = east_full[36:0];
            end else begin
               east_in = east_full[64] ? {1'b1, 36'b0} : {1'b0, {36{1'b1}}};
            end
            status_in = STATUS_POSITION;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_count_in   = count_ff;
               rsp_east_in    = east_ff;
               rsp_north_in   = north_ff;
               rsp_ref_lat_in = ref_lat_ff;
               rsp_ref_lon_in = ref_lon_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sat_thr_ff   <= SAT_THRESHOLD_RESET;
         target_ff    <= SAMPLE_TARGET_RESET;
         limit_ff     <= STABILITY_LIMIT_RESET;
         prev_lat_ff  <= '0;
         prev_lon_ff  <= '0;
         lat_sum_ff   <= '0;
         lon_sum_ff   <= '0;
         count_ff     <= '0;
         ref_lat_ff   <= '0;
         ref_lon_ff   <= '0;
         cos_ff       <= '0;
         ref_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_lat_ff  <= prev_lat_in;
         prev_lon_ff  <= prev_lon_in;
         lat_sum_ff   <= lat_sum_in;
         lon_sum_ff   <= lon_sum_in;
         count_ff     <= count_in;
         ref_lat_ff   <= ref_lat_in;
         ref_lon_ff   <= ref_lon_in;
         cos_ff       <= cos_in;
         ref_valid_ff <= ref_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_SAT_THRESHOLD:   sat_thr_ff <= csr_wdata[7:0];
               CSR_SAMPLE_TARGET:   target_ff  <= csr_wdata[15:0];
               CSR_STABILITY_LIMIT: limit_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      lat_ff         <= lat_in;
      lon_ff         <= lon_in;
      sats_ff        <= sats_in;
      prod_ff        <= prod_in;
      acc_ff         <= acc_in;
      part_ff        <= part_in;
      north_ff       <= north_in;
      east_ff        <= east_in;
      status_ff      <= status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_east_ff    <= rsp_east_in;
      rsp_north_ff   <= rsp_north_in;
      rsp_ref_lat_ff <= rsp_ref_lat_in;
      rsp_ref_lon_ff <= rsp_ref_lon_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_ref_lon_ff, rsp_ref_lat_ff, rsp_north_ff, rsp_east_ff, rsp_count_ff};

   // Once set, the reference stays set until reset.
   assert property (@(posedge clock) disable iff (reset)
      $past(ref_valid_ff) |-> ref_valid_ff)
      else $error("reference valid dropped without reset");

   // A position result can only be produced against a valid reference.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_POSITION) |-> ref_valid_ff)
      else $error("position result without reference");

   // The divider only reports completion while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_LAT_WAIT) || (state_ff == ST_DIV_LON_WAIT))
      else $error("divider finished outside a wait state");

endmodule

FILE: rtl/core/gra_div.sv
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// Depends on gra_pkg for the default operand widths.
module gra_div import gra_pkg::*; #(
   parameter int DIVIDEND_BITS = DIVIDEND_W,
   parameter int DIVISOR_BITS  = DIVISOR_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     done,
   output logic [DIVIDEND_BITS-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_BITS);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  dsr_ff, dsr_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS:0]    trial;
   logic [DIVISOR_BITS:0]    diff;

   assign trial = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // The quotient bit replaces the dividend bit just shifted out.
         if (!diff[DIVISOR_BITS]) begin
            rem_in = diff[DIVISOR_BITS-1:0];
            quo_in = {quo_ff[DIVIDEND_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_BITS-1:0];
            quo_in = {quo_ff[DIVIDEND_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIVIDEND_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/core/gra_cordic.sv
// Rotation-mode CORDIC giving the cosine of a latitude as unsigned Q1.17.
// Depends on gra_pkg for the start value, quarter turn and arctangent table.
module gra_cordic import gra_pkg::*; #(
   parameter int COSINE_STEPS = COSINE_STEPS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [30:0] angle,
   output logic               done,
   output logic [17:0]        cosine
);

   localparam int STEP_W = $clog2(COSINE_STEPS);

   logic                     busy_ff, busy_in;
   logic                     fin_ff, fin_in;
   logic                     done_ff, done_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic signed [33:0]       x_ff, x_in, y_ff, y_in, dx, dy;
   logic signed [32:0]       z_ff, z_in, at;
   logic [32:0]              mag;
   logic [17:0]              cos_ff, cos_in;
   logic signed [34:0]       rnd;
   logic signed [21:0]       r;

   assign mag = angle[30] ? 33'(-{{2{angle[30]}}, angle}) : {2'b00, angle};
   assign dx  = y_ff >>> step_ff;
   assign dy  = x_ff >>> step_ff;
   assign at  = $signed({4'b0000, atan_lookup(5'(step_ff))});
   assign rnd = {x_ff[33], x_ff} + 35'sd4096;
   assign r   = rnd[34:13];

   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      step_in = step_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cos_in  = cos_ff;
      if (start) begin
         step_in = '0;
         x_in    = CORDIC_START_X;
         y_in    = '0;
         z_in    = $signed(mag);
         if (mag > QUARTER_TURN) begin
            // Beyond a pole the cosine is taken as zero.
            cos_in  = '0;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (!z_ff[32]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(COSINE_STEPS - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         if (r[21]) begin
            cos_in = '0;
         end else if (r > 22'sd131072) begin
            cos_in = 18'd131072;
         end else begin
            cos_in = r[17:0];
         end
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      cos_ff <= cos_in;
   end

   assign done   = done_ff;
   assign cosine = cos_ff;

endmodule
